// ----- design/aars_pkg.sv -----
// Shared types and constants of the acknowledgement-line scanner.
`default_nettype none

package aars_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned RESP_W = 2;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;

    localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST     = 8'd2;
    localparam logic [BYTE_W-1:0] EXPECTED_SOURCE_RST = 8'd0;

    localparam logic REG_OWN_ADDRESS     = 1'b0;
    localparam logic REG_EXPECTED_SOURCE = 1'b1;

    localparam logic [RESP_W-1:0] RESP_NONE = 2'd0;
    localparam logic [RESP_W-1:0] RESP_OK   = 2'd1;
    localparam logic [RESP_W-1:0] RESP_NOK  = 2'd2;
    localparam logic [RESP_W-1:0] RESP_RSVD = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DST,
        PH_SRC,
        PH_REPLY
    } t_phase;

    typedef enum logic [2:0] {
        RP_EMPTY,
        RP_O,
        RP_N,
        RP_NO,
        RP_FAIL
    } t_reply;

    typedef struct packed {
        logic [BYTE_W-1:0] own_address;
        logic [BYTE_W-1:0] expected_source;
    } t_cfg;

endpackage

`default_nettype wire

// ----- design/aars_cfg.sv -----
// Configuration register file on an APB-style port.
`default_nettype none

module aars_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aars_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aars_pkg::DATA_W-1:0]   pwdata,
    output logic      [aars_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output aars_pkg::t_cfg                     o_cfg
);

    aars_pkg::t_cfg r_cfg;
    logic           w_write;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address     <= aars_pkg::OWN_ADDRESS_RST;
            r_cfg.expected_source <= aars_pkg::EXPECTED_SOURCE_RST;
        end else if (w_write) begin
            unique case (paddr[2])
                aars_pkg::REG_OWN_ADDRESS: begin
                    r_cfg.own_address <= pwdata[aars_pkg::BYTE_W-1:0];
                end
                aars_pkg::REG_EXPECTED_SOURCE: begin
                    r_cfg.expected_source <= pwdata[aars_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            aars_pkg::REG_OWN_ADDRESS: begin
                prdata = {{(aars_pkg::DATA_W-aars_pkg::BYTE_W){1'b0}}, r_cfg.own_address};
            end
            aars_pkg::REG_EXPECTED_SOURCE: begin
                prdata = {{(aars_pkg::DATA_W-aars_pkg::BYTE_W){1'b0}},
                          r_cfg.expected_source};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/aars_scan.sv -----
// Scanner state and per-byte next-state and response logic.
`default_nettype none

module aars_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [aars_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire aars_pkg::t_cfg                i_cfg,
    output logic      [aars_pkg::RESP_W-1:0]   o_response
);

    aars_pkg::t_phase            r_phase, n_phase;
    aars_pkg::t_reply            r_reply, n_reply;
    logic [aars_pkg::BYTE_W-1:0] r_value, n_value;
    logic                        r_digit, n_digit;
    logic                        r_bad, n_bad;

    logic                        w_live;
    logic                        w_is_digit;
    logic [11:0]                 w_prod;
    logic                        w_over;
    logic                        w_tok_ok;
    logic                        w_dst_match;
    logic                        w_src_match;

    assign w_live      = i_accept && (i_rx_byte != aars_pkg::CH_NUL);
    assign w_is_digit  = (i_rx_byte >= aars_pkg::CH_ZERO) && (i_rx_byte <= aars_pkg::CH_NINE);
    assign w_prod      = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1)
                       + {8'b0, i_rx_byte[3:0]};
    assign w_over      = |w_prod[11:8];
    assign w_tok_ok    = r_digit && !r_bad;
    assign w_dst_match = w_tok_ok && (r_value == i_cfg.own_address);
    assign w_src_match = w_tok_ok && (r_value == i_cfg.expected_source);

    always_comb begin
        n_phase = r_phase;
        if (w_live) begin
            if (i_rx_byte == aars_pkg::CH_AT) begin
                n_phase = aars_pkg::PH_DST;
            end else begin
                unique case (r_phase)
                    aars_pkg::PH_IDLE: begin
                        n_phase = aars_pkg::PH_IDLE;
                    end
                    aars_pkg::PH_DST: begin
                        if (i_rx_byte == aars_pkg::CH_SPACE) begin
                            if (w_dst_match) n_phase = aars_pkg::PH_SRC;
                        end else if (i_rx_byte == aars_pkg::CH_LF) begin
                            n_phase = aars_pkg::PH_IDLE;
                        end
                    end
                    aars_pkg::PH_SRC: begin
                        if (i_rx_byte == aars_pkg::CH_SPACE) begin
                            n_phase = w_src_match ? aars_pkg::PH_REPLY : aars_pkg::PH_IDLE;
                        end else if (i_rx_byte == aars_pkg::CH_LF) begin
                            n_phase = aars_pkg::PH_IDLE;
                        end
                    end
                    aars_pkg::PH_REPLY: begin
                        if (i_rx_byte == aars_pkg::CH_LF) begin
                            n_phase = aars_pkg::PH_IDLE;
                        end else if (i_rx_byte == aars_pkg::CH_K &&
                                     (r_reply == aars_pkg::RP_O || r_reply == aars_pkg::RP_NO)) begin
                            n_phase = aars_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = aars_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_value    = r_value;
        n_digit    = r_digit;
        n_bad      = r_bad;
        n_reply    = r_reply;
        o_response = aars_pkg::RESP_NONE;
        if (w_live) begin
            if (i_rx_byte == aars_pkg::CH_AT) begin
                n_value = '0;
                n_digit = 1'b0;
                n_bad   = 1'b0;
            end else if (r_phase == aars_pkg::PH_DST || r_phase == aars_pkg::PH_SRC) begin
                if (i_rx_byte == aars_pkg::CH_SPACE) begin
                    n_value = '0;
                    n_digit = 1'b0;
                    n_bad   = 1'b0;
                    if (r_phase == aars_pkg::PH_SRC && w_src_match) n_reply = aars_pkg::RP_EMPTY;
                end else if (i_rx_byte != aars_pkg::CH_LF) begin
                    if (w_is_digit) begin
                        n_digit = 1'b1;
                        if (w_over) n_bad = 1'b1;
                        else n_value = w_prod[aars_pkg::BYTE_W-1:0];
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end else if (r_phase == aars_pkg::PH_REPLY && i_rx_byte != aars_pkg::CH_LF) begin
                if (r_reply == aars_pkg::RP_EMPTY && i_rx_byte == aars_pkg::CH_O) begin
                    n_reply = aars_pkg::RP_O;
                end else if (r_reply == aars_pkg::RP_EMPTY && i_rx_byte == aars_pkg::CH_N) begin
                    n_reply = aars_pkg::RP_N;
                end else if (r_reply == aars_pkg::RP_N && i_rx_byte == aars_pkg::CH_O) begin
                    n_reply = aars_pkg::RP_NO;
                end else if (r_reply == aars_pkg::RP_O && i_rx_byte == aars_pkg::CH_K) begin
                    n_reply    = aars_pkg::RP_EMPTY;
                    o_response = aars_pkg::RESP_OK;
                end else if (r_reply == aars_pkg::RP_NO && i_rx_byte == aars_pkg::CH_K) begin
                    n_reply    = aars_pkg::RP_EMPTY;
                    o_response = aars_pkg::RESP_NOK;
                end else begin
                    n_reply = aars_pkg::RP_FAIL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aars_pkg::PH_IDLE;
            r_reply <= aars_pkg::RP_EMPTY;
            r_value <= '0;
            r_digit <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_reply <= n_reply;
            r_value <= n_value;
            r_digit <= n_digit;
            r_bad   <= n_bad;
        end
    end

endmodule

`default_nettype wire

// ----- design/aars_out.sv -----
// Result register with a skid entry between scanner and receiver.
`default_nettype none

module aars_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [aars_pkg::RESP_W-1:0]   i_response,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output logic      [aars_pkg::RESP_W-1:0]   o_response,
    output logic                               o_full
);

    logic                        r_out_valid, n_out_valid;
    logic                        r_skid_valid, n_skid_valid;
    logic [aars_pkg::RESP_W-1:0] r_out, n_out;
    logic [aars_pkg::RESP_W-1:0] r_skid, n_skid;
    logic                        w_take;

    assign w_take = r_out_valid && i_pop;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            n_out_valid = i_push;
            if (i_push) n_out = i_response;
        end else if (i_push) begin
            n_skid       = i_response;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid    = r_out_valid;
    assign o_response = r_out;
    assign o_full     = r_skid_valid;

endmodule

`default_nettype wire

// ----- design/addressed_ack_response_scanner_unit.sv -----
// Top level of the addressed acknowledgement-line scanner.
// Input channel: i_in_valid / o_in_ready carry one received byte (i_rx_byte).
// Output channel: o_out_valid / i_out_ready carry one response per byte:
//   RESP_NONE while scanning, RESP_OK or RESP_NOK on the byte that completes
//   "@<own_address> <expected_source> OK" or "... NOK".
// Configuration: APB-style port, own_address at 0x0, expected_source at 0x4;
//   write only while no item is in flight.
// Each response is registered in the result register, or in the skid entry.
// Throughput: one byte per cycle while o_in_ready is high; the scanner
//   state update is a single registered step with no loop over cycles.
// Reset (synchronous, active low): own_address 2, expected_source 0, scanner
//   idle, no result pending.
// Stall: a result register plus one skid entry hold responses; o_in_ready
//   drops only while both are full, and rises once the receiver takes one.
`default_nettype none

module addressed_ack_response_scanner_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [aars_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [aars_pkg::RESP_W-1:0]   o_response,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aars_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aars_pkg::DATA_W-1:0]   pwdata,
    output logic      [aars_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    aars_pkg::t_cfg              w_cfg;
    logic                        w_accept;
    logic                        w_full;
    logic [aars_pkg::RESP_W-1:0] w_response;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    aars_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    aars_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (w_cfg),
        .o_response (w_response)
    );

    aars_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_response (w_response),
        .i_pop      (i_out_ready),
        .o_valid    (o_out_valid),
        .o_response (o_response),
        .o_full     (w_full)
    );

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_out_valid)
        else $error("skid entry held without a valid result");

    a_resp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_response != aars_pkg::RESP_RSVD))
        else $error("reserved response code on output");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !o_out_valid) |=> o_out_valid)
        else $error("accepted item did not reach the result register");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && !i_out_ready) |=> !o_in_ready)
        else $error("input ready while both result entries are held");
`endif

endmodule

`default_nettype wire

// ----- bench/addressed_ack_response_scanner_unit_tb.sv -----
// Testbench for the acknowledgement-line scanner: random lines against a built-in predictor.
`timescale 1ns / 100ps

module addressed_ack_response_scanner_unit_tb;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int NUM_PHASES      = 8;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              o_in_ready;
    logic [aars_pkg::BYTE_W-1:0]       rx_byte = '0;
    logic                              o_out_valid;
    logic                              out_ready = 1'b0;
    logic [aars_pkg::RESP_W-1:0]       o_response;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [aars_pkg::ADDR_W-1:0]       paddr = '0;
    logic [aars_pkg::DATA_W-1:0]       pwdata = '0;
    logic [aars_pkg::DATA_W-1:0]       prdata;
    logic                              pready;

    addressed_ack_response_scanner_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_response  (o_response),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("timeout");
        $display("[addressed_ack_response_scanner_unit] ERROR");
        $finish;
    end

    // scanner copy
    logic [aars_pkg::BYTE_W-1:0] cfg_own = aars_pkg::OWN_ADDRESS_RST;
    logic [aars_pkg::BYTE_W-1:0] cfg_src = aars_pkg::EXPECTED_SOURCE_RST;
    aars_pkg::t_phase            sc_phase = aars_pkg::PH_IDLE;
    aars_pkg::t_reply            sc_reply = aars_pkg::RP_EMPTY;
    logic [aars_pkg::BYTE_W-1:0] tok_value = '0;
    logic                        tok_digit = 1'b0;
    logic                        tok_bad = 1'b0;

    logic [aars_pkg::BYTE_W-1:0] rx_q[$];
    logic [aars_pkg::RESP_W-1:0] ack_q[$];
    int                          err_count = 0;
    int                          queued = 0;
    bit                          sprinkle_nul = 1'b0;

    function automatic void tok_clear();
        tok_value = '0;
        tok_digit = 1'b0;
        tok_bad   = 1'b0;
    endfunction

    function automatic void tok_add(input logic [aars_pkg::BYTE_W-1:0] b);
        int v;
        if (b >= aars_pkg::CH_ZERO && b <= aars_pkg::CH_NINE) begin
            v = int'(tok_value) * 10 + int'(b - aars_pkg::CH_ZERO);
            if (v > 255) begin
                tok_bad = 1'b1;
            end else begin
                tok_value = v[aars_pkg::BYTE_W-1:0];
            end
            tok_digit = 1'b1;
        end else begin
            tok_bad = 1'b1;
        end
    endfunction

    function automatic bit tok_match(input logic [aars_pkg::BYTE_W-1:0] target);
        return tok_digit && !tok_bad && tok_value == target;
    endfunction

    function automatic logic [aars_pkg::RESP_W-1:0] scan_byte(
        input logic [aars_pkg::BYTE_W-1:0] b
    );
        logic [aars_pkg::RESP_W-1:0] resp;
        resp = aars_pkg::RESP_NONE;
        if (b == aars_pkg::CH_NUL) begin
            return aars_pkg::RESP_NONE;
        end
        if (b == aars_pkg::CH_AT) begin
            sc_phase = aars_pkg::PH_DST;
            tok_clear();
            return aars_pkg::RESP_NONE;
        end
        case (sc_phase)
            aars_pkg::PH_DST: begin
                if (b == aars_pkg::CH_SPACE) begin
                    if (tok_match(cfg_own)) begin
                        sc_phase = aars_pkg::PH_SRC;
                    end
                    tok_clear();
                end else if (b == aars_pkg::CH_LF) begin
                    sc_phase = aars_pkg::PH_IDLE;
                end else begin
                    tok_add(b);
                end
            end
            aars_pkg::PH_SRC: begin
                if (b == aars_pkg::CH_SPACE) begin
                    if (tok_match(cfg_src)) begin
                        sc_phase = aars_pkg::PH_REPLY;
                        sc_reply = aars_pkg::RP_EMPTY;
                    end else begin
                        sc_phase = aars_pkg::PH_IDLE;
                    end
                    tok_clear();
                end else if (b == aars_pkg::CH_LF) begin
                    sc_phase = aars_pkg::PH_IDLE;
                end else begin
                    tok_add(b);
                end
            end
            aars_pkg::PH_REPLY: begin
                if (b == aars_pkg::CH_LF) begin
                    sc_phase = aars_pkg::PH_IDLE;
                end else if (sc_reply == aars_pkg::RP_EMPTY && b == aars_pkg::CH_O) begin
                    sc_reply = aars_pkg::RP_O;
                end else if (sc_reply == aars_pkg::RP_EMPTY && b == aars_pkg::CH_N) begin
                    sc_reply = aars_pkg::RP_N;
                end else if (sc_reply == aars_pkg::RP_N && b == aars_pkg::CH_O) begin
                    sc_reply = aars_pkg::RP_NO;
                end else if (sc_reply == aars_pkg::RP_O && b == aars_pkg::CH_K) begin
                    resp     = aars_pkg::RESP_OK;
                    sc_phase = aars_pkg::PH_IDLE;
                    sc_reply = aars_pkg::RP_EMPTY;
                end else if (sc_reply == aars_pkg::RP_NO && b == aars_pkg::CH_K) begin
                    resp     = aars_pkg::RESP_NOK;
                    sc_phase = aars_pkg::PH_IDLE;
                    sc_reply = aars_pkg::RP_EMPTY;
                end else begin
                    sc_reply = aars_pkg::RP_FAIL;
                end
            end
            default: begin
                sc_phase = aars_pkg::PH_IDLE;
            end
        endcase
        return resp;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                ack_q.push_back(scan_byte(rx_byte));
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (rx_q.size() > 0) begin
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                  : $urandom_range(1, 16);
                    end
                    in_valid <= 1'b1;
                    rx_byte  <= rx_q.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes mode every so often
    int stall_mode = 0;
    int mode_left = 0;
    int cyc = 0;

    always @(posedge i_clk) begin
        logic [aars_pkg::RESP_W-1:0] want;
        cyc++;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (ack_q.size() == 0) begin
                report_mismatch($sformatf("unexpected response %0d", o_response));
            end else begin
                want = ack_q.pop_front();
                if (o_response !== want) begin
                    report_mismatch($sformatf("response got %0d want %0d", o_response, want));
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cyc % 4 == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic emit(input logic [aars_pkg::BYTE_W-1:0] b);
        if (sprinkle_nul && $urandom_range(0, 32) == 0) begin
            rx_q.push_back(aars_pkg::CH_NUL);
            queued++;
        end
        rx_q.push_back(b);
        queued++;
    endtask

    task automatic emit_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            emit(s[i]);
        end
    endtask

    task automatic emit_junk();
        logic [aars_pkg::BYTE_W-1:0] c;
        do begin
            c = 8'($urandom_range(33, 126));
        end while ((c >= aars_pkg::CH_ZERO && c <= aars_pkg::CH_NINE) || c == aars_pkg::CH_AT);
        emit(c);
    endtask

    task automatic gen_token(input logic [aars_pkg::BYTE_W-1:0] target, input bit good);
        int kind;
        int zeros;
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        kind  = good ? 0 : $urandom_range(1, 4);
        case (kind)
            0: begin
                repeat (zeros) emit(aars_pkg::CH_ZERO);
                emit_str($sformatf("%0d", target));
            end
            1: emit_str($sformatf("%0d", target ^ 8'($urandom_range(1, 255))));
            2: begin
                repeat (zeros) emit(aars_pkg::CH_ZERO);
                emit_str($sformatf("%0d", 256 + $urandom_range(0, 743)));
            end
            3: ;
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    emit_str($sformatf("%0d", target));
                    emit_junk();
                end else begin
                    emit_junk();
                    emit_str($sformatf("%0d", target));
                end
            end
        endcase
    endtask

    task automatic gen_reply();
        case ($urandom_range(0, 9))
            0, 1, 2: emit_str("OK");
            3, 4, 5: emit_str("NOK");
            6: begin
                case ($urandom_range(0, 2))
                    0:       emit(aars_pkg::CH_O);
                    1:       emit(aars_pkg::CH_N);
                    default: emit_str("NO");
                endcase
                emit_junk();
                emit_str("OK");
            end
            7: begin
                emit_junk();
                emit_str("NOK");
            end
            8: emit_str("NKOK");
            default: begin
                emit(aars_pkg::CH_O);
                emit(aars_pkg::CH_LF);
                emit(aars_pkg::CH_K);
            end
        endcase
    endtask

    task automatic gen_line();
        int n;
        if ($urandom_range(0, 99) < 75) begin
            emit(aars_pkg::CH_AT);
            if ($urandom_range(0, 9) == 0) begin
                gen_token(8'($urandom), $urandom_range(0, 1) == 1);
                emit(aars_pkg::CH_AT);
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) begin
                gen_token(cfg_own, 1'b0);
                emit(aars_pkg::CH_SPACE);
            end
            gen_token(cfg_own, $urandom_range(0, 99) < 88);
            emit(($urandom_range(0, 19) == 0) ? aars_pkg::CH_LF : aars_pkg::CH_SPACE);
            gen_token(cfg_src, $urandom_range(0, 99) < 88);
            emit(($urandom_range(0, 19) == 0) ? aars_pkg::CH_LF : aars_pkg::CH_SPACE);
            gen_reply();
            if ($urandom_range(0, 1) == 1) begin
                emit(aars_pkg::CH_LF);
            end
        end else begin
            repeat ($urandom_range(1, 6)) emit(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [aars_pkg::BYTE_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == aars_pkg::REG_OWN_ADDRESS) begin
            cfg_own = val;
        end else begin
            cfg_src = val;
        end
    endtask

    task automatic wait_drained();
        while (rx_q.size() != 0 || in_valid || ack_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int start;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: ;
                1: begin
                    cfg_write(aars_pkg::REG_OWN_ADDRESS, 8'd0);
                    cfg_write(aars_pkg::REG_EXPECTED_SOURCE, 8'd255);
                end
                2: begin
                    cfg_write(aars_pkg::REG_OWN_ADDRESS, 8'd255);
                    cfg_write(aars_pkg::REG_EXPECTED_SOURCE, 8'd0);
                end
                3: cfg_write(aars_pkg::REG_EXPECTED_SOURCE, 8'd255);
                4: begin
                    cfg_write(aars_pkg::REG_OWN_ADDRESS, 8'd0);
                    cfg_write(aars_pkg::REG_EXPECTED_SOURCE, 8'd0);
                end
                default: begin
                    cfg_write(aars_pkg::REG_OWN_ADDRESS, 8'($urandom));
                    cfg_write(aars_pkg::REG_EXPECTED_SOURCE, 8'($urandom));
                end
            endcase
            start = queued;
            if (p == 0) begin
                sprinkle_nul = 1'b0;
                emit(aars_pkg::CH_NUL);
                emit(8'hFF);
                emit(8'h7F);
                emit_str("@2 0 OK");
                emit_str("@2 0 N");
                emit(aars_pkg::CH_NUL);
                emit_str("OK");
                emit(aars_pkg::CH_LF);
                emit_str("@02 0 NOK");
            end
            sprinkle_nul = 1'b1;
            while (queued - start < ITEMS_PER_PHASE) begin
                gen_line();
            end
            wait_drained();
        end
        if (err_count == 0 && ack_q.size() == 0) begin
            $display("[addressed_ack_response_scanner_unit] OK");
        end else begin
            $display("[addressed_ack_response_scanner_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/aars_pkg.sv
design/aars_cfg.sv
design/aars_scan.sv
design/aars_out.sv
design/addressed_ack_response_scanner_unit.sv
bench/addressed_ack_response_scanner_unit_tb.sv
